@@ design/ksc_pkg.sv @@
// shared types and constants for the keypad scan and code entry block
package ksc_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_ARM   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_CODE   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_KEYMAP_LO = 2'd0;
    localparam logic [1:0] CFG_KEYMAP_HI = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    localparam logic [7:0]  CHAR_STAR      = 8'h2A;
    localparam logic [7:0]  CHAR_HASH      = 8'h23;
    localparam logic [9:0]  DEBOUNCE_RESET = 10'd10;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;
    localparam logic [9:0]  DEBOUNCE_MAX   = 10'h3FF;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] column_sample;
        logic [3:0] arm_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] char_value;
        logic [1:0] row_index;
        logic       key_released;
        logic       timeout_event;
        logic       entry_active;
        logic       last_result;
    } t_out_item;

    // classified request passed from front to back
    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] sample;
        logic       sample_idle;
        logic [3:0] arm_length;
    } t_cmd;

    typedef struct packed {
        logic [127:0] keymap;
        logic [9:0]   debounce_ticks;
        logic [15:0]  timeout_ticks;
    } t_cfg;

endpackage

@@ design/ksc_front.sv @@
// front end: accepts requests, classifies the column sample and queues commands
module ksc_front import ksc_pkg::*; #(
    parameter int COLS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    output logic     o_cmd_vld,
    input  logic     i_cmd_rdy,
    output t_cmd     o_cmd
);

    localparam logic [3:0] COL_MASK = 4'((1 << COLS) - 1);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.req_type    = i_item.req_type;
        w_cmd.sample      = i_item.column_sample & COL_MASK;
        w_cmd.sample_idle = ((i_item.column_sample & COL_MASK) == COL_MASK);
        w_cmd.arm_length  = i_item.arm_length;
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];
    assign w_push    = i_push && !o_full;
    assign w_pop     = o_cmd_vld && i_cmd_rdy;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ design/ksc_back.sv @@
// back end: scan state, debounce, code entry and serial result output
module ksc_back import ksc_pkg::*; #(
    parameter int ROWS         = 4,
    parameter int COLS         = 4,
    parameter int MAX_CODE_LEN = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_vld,
    output logic      o_cmd_rdy,
    input  t_cmd      i_cmd,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int LW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam logic [3:0]    MAX_LEN  = 4'(MAX_CODE_LEN);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_COL    = 2'd1;
    localparam logic [1:0] S_CODE   = 2'd2;
    localparam logic [1:0] S_STATUS = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [1:0]      r_row, n_row;
    logic            r_wait, n_wait;
    logic [9:0]      r_deb, n_deb;
    logic [15:0]     r_idle, n_idle;
    logic [3:0]      r_len, n_len;
    logic [3:0]      r_armed, n_armed;
    logic [COLS-1:0] r_sample, n_sample;
    logic [CW-1:0]   r_col, n_col;
    logic [LW-1:0]   r_idx, n_idx;
    logic            r_done, n_done;
    logic            r_rel, n_rel;
    logic            r_tmo, n_tmo;
    t_out_item       r_out, n_out;
    logic            r_out_vld, n_out_vld;
    logic [7:0]      r_chars [MAX_CODE_LEN];

    logic        w_slot;
    logic [3:0]  w_code;
    logic [7:0]  w_ch;
    logic        w_key_low;
    logic [3:0]  w_len_app;
    logic        w_fin;
    logic [9:0]  w_deb_inc;
    logic [15:0] w_idle_inc;
    logic [1:0]  w_row_next;
    logic [2:0]  w_row_sum;
    logic        w_wr;

    assign w_slot     = !r_out_vld || i_pop;
    assign w_code     = 4'(r_row) * 4'(COLS) + 4'(r_col);
    assign w_ch       = i_cfg.keymap[{w_code, 3'b000} +: 8];
    assign w_key_low  = !r_sample[r_col];
    assign w_len_app  = (r_len < MAX_LEN) ? r_len + 4'd1 : r_len;
    assign w_fin      = (w_len_app >= MAX_LEN) ||
                        ((r_armed != 4'd0) && (w_len_app >= r_armed));
    assign w_deb_inc  = (r_deb < DEBOUNCE_MAX) ? r_deb + 10'd1 : r_deb;
    assign w_idle_inc = (r_idle < IDLE_MAX) ? r_idle + 16'd1 : r_idle;
    assign w_row_sum  = {1'b0, r_row} + 3'd1;
    assign w_row_next = (w_row_sum < 3'(ROWS)) ? w_row_sum[1:0] : 2'd0;

    assign o_cmd_rdy = (r_state == S_IDLE);
    assign o_empty   = !r_out_vld;
    assign o_result  = r_out;

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_wait    = r_wait;
        n_deb     = r_deb;
        n_idle    = r_idle;
        n_len     = r_len;
        n_armed   = r_armed;
        n_sample  = r_sample;
        n_col     = r_col;
        n_idx     = r_idx;
        n_done    = r_done;
        n_rel     = r_rel;
        n_tmo     = r_tmo;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;
        w_wr      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    n_rel    = 1'b0;
                    n_tmo    = 1'b0;
                    n_state  = S_STATUS;
                    case (i_cmd.req_type)
                        REQ_ARM: begin
                            n_armed = i_cmd.arm_length;
                        end
                        REQ_CLEAR: begin
                            n_len  = 4'd0;
                            n_idle = 16'd0;
                        end
                        REQ_TICK: begin
                            if (!i_cmd.sample_idle) begin
                                n_idle = 16'd0;
                                if (!r_wait) begin
                                    if (w_deb_inc >= i_cfg.debounce_ticks) begin
                                        n_wait   = 1'b1;
                                        n_deb    = 10'd0;
                                        n_col    = '0;
                                        n_done   = 1'b0;
                                        n_sample = i_cmd.sample[COLS-1:0];
                                        n_state  = S_COL;
                                    end else begin
                                        n_deb = w_deb_inc;
                                    end
                                end
                            end else if (r_wait) begin
                                n_wait = 1'b0;
                                n_deb  = 10'd0;
                                n_rel  = 1'b1;
                            end else begin
                                n_deb = 10'd0;
                                n_row = w_row_next;
                                if (w_idle_inc >= i_cfg.timeout_ticks) begin
                                    n_idle = 16'd0;
                                    n_len  = 4'd0;
                                    n_tmo  = 1'b1;
                                end else begin
                                    n_idle = w_idle_inc;
                                end
                            end
                        end
                        default: begin
                            n_state = S_STATUS;
                        end
                    endcase
                end
            end

            S_COL: begin
                if (!w_key_low || w_slot) begin
                    if (w_key_low) begin
                        n_out_vld         = 1'b1;
                        n_out             = '0;
                        n_out.result_kind = KIND_KEY;
                        n_out.char_value  = w_ch;
                    end
                    // a completion detours through the code output before the next column
                    if (w_key_low && !r_done && (w_ch == CHAR_STAR)) begin
                        n_len = 4'd0;
                    end else if (w_key_low && !r_done && (w_ch == CHAR_HASH)) begin
                        if (r_len != 4'd0) begin
                            n_done  = 1'b1;
                            n_idx   = '0;
                            n_state = S_CODE;
                        end
                    end else if (w_key_low && !r_done) begin
                        w_wr  = (r_len < MAX_LEN);
                        n_len = w_len_app;
                        if (w_fin) begin
                            n_done  = 1'b1;
                            n_idx   = '0;
                            n_state = S_CODE;
                        end
                    end
                    if (n_state == S_COL) begin
                        if (r_col == LAST_COL) begin
                            n_state = S_STATUS;
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                end
            end

            S_CODE: begin
                if (w_slot) begin
                    n_out_vld         = 1'b1;
                    n_out             = '0;
                    n_out.result_kind = KIND_CODE;
                    n_out.char_value  = r_chars[r_idx];
                    if (4'(r_idx) == r_len - 4'd1) begin
                        n_len   = 4'd0;
                        n_armed = 4'd0;
                        if (r_col == LAST_COL) begin
                            n_state = S_STATUS;
                        end else begin
                            n_col   = r_col + CW'(1);
                            n_state = S_COL;
                        end
                    end else begin
                        n_idx = r_idx + LW'(1);
                    end
                end
            end

            S_STATUS: begin
                if (w_slot) begin
                    n_out_vld           = 1'b1;
                    n_out               = '0;
                    n_out.result_kind   = KIND_STATUS;
                    n_out.row_index     = r_row;
                    n_out.key_released  = r_rel;
                    n_out.timeout_event = r_tmo;
                    n_out.entry_active  = (r_len != 4'd0) || (r_armed != 4'd0);
                    n_out.last_result   = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_chars[r_len[LW-1:0]] <= w_ch;
        end
        r_out    <= n_out;
        r_sample <= n_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= 2'd0;
            r_wait    <= 1'b0;
            r_deb     <= 10'd0;
            r_idle    <= 16'd0;
            r_len     <= 4'd0;
            r_armed   <= 4'd0;
            r_col     <= '0;
            r_idx     <= '0;
            r_done    <= 1'b0;
            r_rel     <= 1'b0;
            r_tmo     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_wait    <= n_wait;
            r_deb     <= n_deb;
            r_idle    <= n_idle;
            r_len     <= n_len;
            r_armed   <= n_armed;
            r_col     <= n_col;
            r_idx     <= n_idx;
            r_done    <= n_done;
            r_rel     <= n_rel;
            r_tmo     <= n_tmo;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

@@ design/keypad_scan_code_entry_top.sv @@
// top level of the keypad scanner with code entry
// Keypad matrix scanner with code entry. Each request is a scan tick carrying the
// active-low column sample of the driven row, an entry-length arm, or an entry
// clear; every request ends with exactly one status beat (last_result set) that
// tells which row to drive next. A debounced press emits one key-down beat per
// low column and, when an entry completes, one beat per code character. Requests
// go through a two-deep command queue into a sequencer that emits one result beat
// per cycle into a single output register while the result side is popped; a
// request steps through idle, the column states of a press tick, the code state
// of a completed entry and status. Configuration writes are always ready.
module keypad_scan_code_entry_top import ksc_pkg::*; #(
    parameter int ROWS         = 4,
    parameter int COLS         = 4,
    parameter int MAX_CODE_LEN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    logic w_cmd_vld;
    logic w_cmd_rdy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keymap         <= 128'd0;
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
            r_cfg.timeout_ticks  <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEYMAP_LO: r_cfg.keymap[63:0]   <= i_cfg_data;
                CFG_KEYMAP_HI: r_cfg.keymap[127:64] <= i_cfg_data;
                CFG_DEBOUNCE:  r_cfg.debounce_ticks <= i_cfg_data[9:0];
                CFG_TIMEOUT:   r_cfg.timeout_ticks  <= i_cfg_data[15:0];
                default:       r_cfg                <= r_cfg;
            endcase
        end
    end

    ksc_front #(
        .COLS(COLS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_item),
        .o_cmd_vld (w_cmd_vld),
        .i_cmd_rdy (w_cmd_rdy),
        .o_cmd     (w_cmd)
    );

    ksc_back #(
        .ROWS         (ROWS),
        .COLS         (COLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd_vld (w_cmd_vld),
        .o_cmd_rdy (w_cmd_rdy),
        .i_cmd     (w_cmd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

@@ design/ksc_checker.sv @@
// port-level checks for the keypad scanner, bound to the top level
module ksc_checker import ksc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_full,
    input logic      i_empty,
    input logic      i_pop,
    input t_out_item i_result
);

    // result side empty and command side not full right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("queues not empty after reset");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && !i_pop |=> !i_empty && $stable(i_result))
        else $error("result changed while stalled");

    // only the status beat closes a request
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (i_result.last_result == (i_result.result_kind == KIND_STATUS)))
        else $error("last_result does not match status beat");

    // key and code beats carry no status bits
    a_char_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty && i_result.result_kind != KIND_STATUS |->
            i_result.row_index == 2'd0 && !i_result.key_released &&
            !i_result.timeout_event && !i_result.entry_active &&
            i_result.result_kind != 2'd3)
        else $error("character beat carries status fields");

endmodule

bind keypad_scan_code_entry_top ksc_checker u_ksc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_full   (full),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);
